[hw/rtl/rrts_pkg.sv]
// Shared types and codes of the round-robin thread scheduler.
package rrts_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned TID_W   = 5;
  localparam int unsigned CPUID_W = 2;
  localparam int unsigned PST_W   = 2;
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 16;

  // Item kinds carried in the input tuser.
  localparam logic KIND_READY = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  // New state reported for the outgoing thread.
  localparam logic [PST_W-1:0] PST_FREE     = 2'd0;
  localparam logic [PST_W-1:0] PST_READY    = 2'd1;
  localparam logic [PST_W-1:0] PST_SLEEPING = 2'd2;
  localparam logic [PST_W-1:0] PST_NONE     = 2'd3;

  // Control for one update of the ready queue.
  typedef struct packed {
    logic fire;    // the current item commits this cycle
    logic append;  // append the given thread at the tail
    logic pop;     // take the head after the append
  } q_cmd_t;

endpackage

[hw/rtl/rrts_ready_queue.sv]
// Ready queue of thread numbers kept as a linked list in a next-pointer memory.
module rrts_ready_queue
  import rrts_pkg::*;
#(
  parameter int NUM_THREADS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  q_cmd_t                         cmd,
  input  logic [$clog2(NUM_THREADS)-1:0] append_id,
  output logic [$clog2(NUM_THREADS)-1:0] chosen
);

  localparam int TW = $clog2(NUM_THREADS);

  // Next-pointer memory; an entry is meaningful once its thread has a successor.
  logic [TW-1:0] link_mem [NUM_THREADS];

  logic [TW-1:0] head;
  logic [TW-1:0] tail;
  logic          empty;
  logic [TW-1:0] head_link;  // copy of link_mem[head], kept in step with writes

  logic [TW-1:0] head_app;
  logic [TW-1:0] tail_next;
  logic [TW-1:0] head_next;
  logic          empty_app;
  logic          empty_next;
  logic          link_wr;
  logic [TW-1:0] link_of_head;

  // Append first, then pop from the resulting queue.
  always_comb begin
    link_wr      = cmd.append && !empty;
    head_app     = (cmd.append && empty) ? append_id : head;
    empty_app    = empty && !cmd.append;
    tail_next    = cmd.append ? append_id : tail;
    // The head's successor was just written when the head is the old tail.
    link_of_head = (link_wr && (head_app == tail)) ? append_id : head_link;

    chosen     = '0;
    head_next  = head_app;
    empty_next = empty_app;
    if (cmd.pop && !empty_app) begin
      chosen = head_app;
      if (head_app == tail_next) begin
        empty_next = 1'b1;
      end else begin
        head_next = link_of_head;
      end
    end
  end

  // Control registers of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else if (cmd.fire) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

  // Memory write at the old tail and registered read of the new head's link.
  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      if (link_wr) begin
        link_mem[tail] <= append_id;
      end
      if (link_wr && (tail == head_next)) begin
        head_link <= append_id;
      end else begin
        head_link <= link_mem[head_next];
      end
    end
  end

endmodule

[hw/rtl/round_robin_thread_scheduler.sv]
// Top level of the round-robin thread scheduler.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  s_tuser: kind; s_tdata: thread, cpu, dying, sleep
//  m_*      out  m_tvalid/m_tready  m_tdata: chosen, previous, new state, rejected
//
// An accepted beat is held in the input register, where the queue update and the
// CPU table update are worked out, and its result is registered in the result
// register when it commits; one beat per cycle sustained while the result side does
// not stall. The CPU table is read as a beat enters the input register, with
// forwarding of the write in flight. Reset is synchronous; the CPU table valid bits
// clear at once. A stalled result holds the input register, which then holds
// s_tready low.
module round_robin_thread_scheduler
  import rrts_pkg::*;
#(
  parameter int NUM_THREADS = 32,
  parameter int NUM_CPUS    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // Bits from the lowest: thread_id[4:0], cpu_id[6:5], cur_is_dying[7],
  // cur_wants_sleep[8], zero fill.
  input  logic [S_DATA_W-1:0] s_tdata,
  // Bits from the lowest: kind[0].
  input  logic [0:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // Bits from the lowest: chosen_thread[4:0], previous_thread[9:5],
  // previous_new_state[11:10], rejected[12], zero fill.
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int TW = $clog2(NUM_THREADS);
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  // Input register.
  logic               a_valid;
  logic               a_kind;
  logic [TID_W-1:0]   a_tid;
  logic [CPUID_W-1:0] a_cpu;
  logic               a_dying;
  logic               a_sleep;
  logic [TW-1:0]      cpu_rd;
  logic               cpu_rd_vld;

  // Current thread of each CPU.
  logic [TW-1:0]       cpu_mem [NUM_CPUS];
  logic [NUM_CPUS-1:0] cpu_valid;

  logic          s_accept;
  logic          fire;
  logic [CW-1:0] s_cpu_idx;
  logic [CW-1:0] a_cpu_idx;
  logic          cpu_ok;
  logic          tid_bad;
  logic          cpu_wr;
  logic [TW-1:0] prev;
  logic [TW-1:0] chosen;
  logic [TW-1:0] append_id;
  q_cmd_t        qcmd;

  logic [TID_W-1:0] res_chosen;
  logic [TID_W-1:0] res_prev;
  logic [PST_W-1:0] res_state;
  logic             res_rej;

  // Handshake of the input register and the result register.
  assign fire      = a_valid && (!m_tvalid || m_tready);
  assign s_tready  = !a_valid || fire;
  assign s_accept  = s_tvalid && s_tready;
  assign s_cpu_idx = CW'(s_tdata[6:5]);
  assign a_cpu_idx = CW'(a_cpu);

  // Decode of the held beat.
  always_comb begin
    cpu_ok    = 32'(a_cpu) < NUM_CPUS;
    tid_bad   = (a_tid == '0) || (32'(a_tid) >= NUM_THREADS);
    prev      = cpu_rd_vld ? cpu_rd : '0;
    append_id = prev;
    qcmd.fire   = fire;
    qcmd.append = 1'b0;
    qcmd.pop    = 1'b0;
    res_state = PST_NONE;
    res_rej   = 1'b0;
    res_prev  = '0;
    if (a_kind == KIND_READY) begin
      append_id   = TW'(a_tid);
      qcmd.append = fire && !tid_bad;
      res_rej     = tid_bad;
    end else if (cpu_ok) begin
      qcmd.pop = fire;
      res_prev = TID_W'(prev);
      if (a_dying) begin
        res_state = PST_FREE;
      end else if (a_sleep) begin
        res_state = PST_SLEEPING;
      end else begin
        res_state   = PST_READY;
        qcmd.append = fire && (prev != '0);
      end
    end
    res_chosen = TID_W'(chosen);
  end

  assign cpu_wr = fire && (a_kind == KIND_SCHED) && cpu_ok;

  rrts_ready_queue #(
    .NUM_THREADS(NUM_THREADS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .cmd      (qcmd),
    .append_id(append_id),
    .chosen   (chosen)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_accept) begin
      a_valid <= 1'b1;
    end else if (fire) begin
      a_valid <= 1'b0;
    end
  end

  // Input payload and the early read of the CPU table with forwarding.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_kind  <= s_tuser[0];
      a_tid   <= s_tdata[4:0];
      a_cpu   <= s_tdata[6:5];
      a_dying <= s_tdata[7];
      a_sleep <= s_tdata[8];
      if (cpu_wr && (a_cpu_idx == s_cpu_idx)) begin
        cpu_rd     <= chosen;
        cpu_rd_vld <= 1'b1;
      end else begin
        cpu_rd     <= cpu_mem[s_cpu_idx];
        cpu_rd_vld <= cpu_valid[s_cpu_idx];
      end
    end
  end

  // CPU table write.
  always_ff @(posedge clk) begin
    if (cpu_wr) begin
      cpu_mem[a_cpu_idx] <= chosen;
    end
  end

  // An entry that was never written reads as the idle thread.
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_valid <= '0;
    end else if (cpu_wr) begin
      cpu_valid[a_cpu_idx] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, res_rej, res_state, res_prev, res_chosen};
    end
  end

  // A held beat with a stalled result keeps the input side closed.
  assert property (@(posedge clk) disable iff (rst)
    a_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while the held beat is stalled");

  // Every committed beat shows up as a result beat.
  assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("committed beat produced no result");

  // A ready request reports no thread change.
  assert property (@(posedge clk) disable iff (rst)
    fire && (a_kind == KIND_READY) |=> (m_tdata[9:0] == '0) && (m_tdata[11:10] == PST_NONE))
    else $error("ready request reported a thread change");

  // A schedule request is never rejected.
  assert property (@(posedge clk) disable iff (rst)
    fire && (a_kind == KIND_SCHED) |=> !m_tdata[12])
    else $error("schedule request flagged as rejected");

endmodule

[tb/round_robin_thread_scheduler_test.sv]
// Self-checking testbench for the round-robin thread scheduler.
module round_robin_thread_scheduler_test
  import rrts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int THREADS = 32;
  localparam int CPUS = 4;
  localparam logic [TID_W-1:0] IDLE_THREAD = '0;
  localparam int IDLE_PCT = 21;
  localparam int RANDOM_ITEMS = 500;

  typedef enum logic [1:0] {TS_FREE, TS_READY, TS_SLEEPING, TS_RUNNING} thread_state_t;

  // One result beat, field by field.
  typedef struct {
    logic [TID_W-1:0] chosen;
    logic [TID_W-1:0] prev;
    logic [PST_W-1:0] pst;
    logic             rejected;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // Bits from the lowest: thread_id[4:0], cpu_id[6:5], cur_is_dying[7],
  // cur_wants_sleep[8], zero fill.
  logic [S_DATA_W-1:0] s_tdata = '0;
  // Bits from the lowest: kind[0].
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // Bits from the lowest: chosen_thread[4:0], previous_thread[9:5],
  // previous_new_state[11:10], rejected[12], zero fill.
  logic [M_DATA_W-1:0] m_tdata;

  // Ready queue and thread table as the scheduler should hold them.
  logic                link_valid [THREADS];
  logic [TID_W-1:0]    link_next [THREADS];
  thread_state_t       thread_state [THREADS];
  logic [TID_W-1:0]    cpu_current [CPUS];
  logic [TID_W-1:0]    q_head = '0;
  logic [TID_W-1:0]    q_tail = '0;
  logic                q_empty = 1'b1;

  sched_result_t pending_results[$];
  logic steady = 1'b0;
  int errors = 0;
  int beats_in = 0;
  int results_checked = 0;
  int idle_picks = 0;
  int rejected_adds = 0;

  round_robin_thread_scheduler #(
    .NUM_THREADS(THREADS),
    .NUM_CPUS(CPUS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // Append a thread at the tail of the ready queue without any check.
  function automatic void enqueue_thread(logic [TID_W-1:0] t);
    if (!q_empty) begin
      link_valid[q_tail] = 1'b1;
      link_next[q_tail] = t;
    end else begin
      q_head = t;
    end
    link_valid[t] = 1'b0;
    q_tail = t;
    q_empty = 1'b0;
  endfunction

  // Advance the scheduler state by one beat and return the result it gives.
  function automatic sched_result_t schedule_outcome(logic kind, logic [TID_W-1:0] tid,
                                                     logic [CPUID_W-1:0] cpu,
                                                     logic dying, logic sleepy);
    sched_result_t r;
    logic [TID_W-1:0] prev;
    logic [TID_W-1:0] chosen;
    r.chosen = '0;
    r.prev = '0;
    r.pst = PST_NONE;
    r.rejected = 1'b0;
    if (kind == KIND_READY) begin
      if (tid == IDLE_THREAD) begin
        r.rejected = 1'b1;
      end else begin
        enqueue_thread(tid);
        thread_state[tid] = TS_READY;
      end
      return r;
    end
    // Retire, park or requeue the outgoing thread; the idle thread is never queued.
    prev = cpu_current[cpu];
    if (dying) begin
      r.pst = PST_FREE;
      thread_state[prev] = TS_FREE;
    end else if (sleepy) begin
      r.pst = PST_SLEEPING;
      thread_state[prev] = TS_SLEEPING;
    end else begin
      if (prev != IDLE_THREAD) enqueue_thread(prev);
      r.pst = PST_READY;
      thread_state[prev] = TS_READY;
    end
    // Pop the head, or fall back to the idle thread.
    chosen = IDLE_THREAD;
    if (!q_empty) begin
      chosen = q_head;
      if (chosen == q_tail || !link_valid[chosen]) q_empty = 1'b1;
      else q_head = link_next[chosen];
    end
    thread_state[chosen] = TS_RUNNING;
    cpu_current[cpu] = chosen;
    r.chosen = chosen;
    r.prev = prev;
    return r;
  endfunction

  // Present one beat, with random gaps before it outside the steady stretch, and record its expected result.
  task automatic send_item(logic kind, logic [TID_W-1:0] tid, logic [CPUID_W-1:0] cpu,
                           logic dying, logic sleepy);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {7'd0, sleepy, dying, cpu, tid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(schedule_outcome(kind, tid, cpu, dying, sleepy));
    beats_in++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Result side: random backpressure except during the steady stretch.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, tdata", int'(m_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.chosen == IDLE_THREAD && want.pst != PST_NONE) idle_picks++;
        if (want.rejected) rejected_adds++;
        if (m_tdata[4:0] !== want.chosen)
          report_mismatch("chosen_thread", int'(m_tdata[4:0]), int'(want.chosen));
        if (m_tdata[9:5] !== want.prev)
          report_mismatch("previous_thread", int'(m_tdata[9:5]), int'(want.prev));
        if (m_tdata[11:10] !== want.pst)
          report_mismatch("previous_new_state", int'(m_tdata[11:10]), int'(want.pst));
        if (m_tdata[12] !== want.rejected)
          report_mismatch("rejected", int'(m_tdata[12]), int'(want.rejected));
      end
    end
  end

  // Adding the idle thread is refused; the highest thread number is accepted.
  task automatic test_ready_and_reject();
    send_item(KIND_READY, 5'd0, 2'd3, 1'b1, 1'b1);
    send_item(KIND_READY, 5'd31, 2'd0, 1'b0, 1'b0);
    send_item(KIND_READY, 5'd1, 2'd0, 1'b0, 1'b0);
  endtask

  // Pops in order, an empty queue yields the idle thread, and the outgoing
  // idle thread turns ready, free or sleeping without being queued.
  task automatic test_schedule_basics();
    send_item(KIND_SCHED, 5'd0, 2'd0, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd1, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd2, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd3, 1'b1, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd2, 1'b0, 1'b1);
  endtask

  // Dying and sleeping threads leave the CPU; a plain switch requeues.
  task automatic test_retire_and_sleep();
    send_item(KIND_SCHED, 5'd0, 2'd0, 1'b1, 1'b1);
    send_item(KIND_SCHED, 5'd0, 2'd1, 1'b0, 1'b1);
    send_item(KIND_READY, 5'd16, 2'd0, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd3, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd3, 1'b0, 1'b0);
  endtask

  // Re-adding a queued thread cuts the queue; re-adding a running one too.
  task automatic test_duplicate_append();
    send_item(KIND_READY, 5'd5, 2'd0, 1'b0, 1'b0);
    send_item(KIND_READY, 5'd6, 2'd0, 1'b0, 1'b0);
    send_item(KIND_READY, 5'd7, 2'd0, 1'b0, 1'b0);
    send_item(KIND_READY, 5'd5, 2'd0, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd0, 1'b0, 1'b0);
    send_item(KIND_READY, 5'd5, 2'd0, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd0, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd1, 1'b0, 1'b0);
  endtask

  // Stop feeding until every result is back, then carry on.
  task automatic test_drain_pause();
    send_item(KIND_READY, 5'd10, 2'd0, 1'b0, 1'b0);
    send_item(KIND_SCHED, 5'd0, 2'd2, 1'b0, 1'b0);
    s_tvalid <= 1'b0;
    wait_drained();
  endtask

  // Mostly well-formed traffic: wake free or sleeping threads and switch CPUs,
  // with some noise adds of arbitrary threads, the idle one included.
  task automatic test_random();
    int cands[$];
    int roll;
    logic [TID_W-1:0] tid;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 150 && n < 300);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        cands.delete();
        for (int t = 1; t < THREADS; t++)
          if (thread_state[t] == TS_FREE || thread_state[t] == TS_SLEEPING) cands.push_back(t);
        if (roll < 38 && cands.size() != 0)
          tid = TID_W'(cands[$urandom_range(0, cands.size() - 1)]);
        else
          tid = TID_W'($urandom_range(0, THREADS - 1));
        send_item(KIND_READY, tid, CPUID_W'($urandom_range(0, CPUS - 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_item(KIND_SCHED, TID_W'($urandom_range(0, THREADS - 1)),
                  CPUID_W'($urandom_range(0, CPUS - 1)),
                  $urandom_range(0, 7) == 0, $urandom_range(0, 4) == 0);
      end
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;
  endtask

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int t = 0; t < THREADS; t++) begin
      link_valid[t] = 1'b0;
      link_next[t] = '0;
      thread_state[t] = TS_FREE;
    end
    thread_state[IDLE_THREAD] = TS_RUNNING;
    for (int c = 0; c < CPUS; c++) cpu_current[c] = IDLE_THREAD;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ready_and_reject();
    test_schedule_basics();
    test_retire_and_sleep();
    test_duplicate_append();
    test_drain_pause();
    test_random();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d beats and checked %0d results across all CPUs.", beats_in,
             results_checked);
    $display("Idle picks on an empty queue: %0d, refused adds of the idle thread: %0d.",
             idle_picks, rejected_adds);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
